FILE: src/sdsc_pkg.sv
// sdsc_pkg: shared types, command codes and frame helper for the sd spi command engine
// no dependencies; used by the channel interfaces, the step logic, the top level and checker
`default_nettype none

package sdsc_pkg;

    // command bytes, fill pattern, command mask, poll limit reset value and last frame and word indices
    localparam logic [7:0] CMD_APP      = 8'h77;
    localparam logic [7:0] CMD_STATUS   = 8'h4D;
    localparam logic [7:0] CMD_IF_COND  = 8'h48;
    localparam logic [7:0] CMD_READ_OCR = 8'h7A;
    localparam logic [7:0] FILL_BYTE    = 8'hFF;
    localparam logic [7:0] CMD_MASK     = 8'h7F;
    localparam logic [7:0] POLL_LIMIT_RESET = 8'd8;
    localparam logic [2:0] LAST_FRAME_IDX   = 3'd5;
    localparam logic [2:0] LAST_WORD_IDX    = 3'd3;

    // item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_BYTE  = 1'b1;

    // exchange phases, one-hot
    typedef enum logic [8:0] {
        PH_IDLE   = 9'b000000001,
        PH_FRAME  = 9'b000000010,
        PH_POLL   = 9'b000000100,
        PH_SDUMMY = 9'b000001000,
        PH_SREAD1 = 9'b000010000,
        PH_SREAD2 = 9'b000100000,
        PH_WORD   = 9'b001000000,
        PH_TRAIL  = 9'b010000000,
        PH_DESEL  = 9'b100000000
    } t_phase;

    // one input beat
    typedef struct packed {
        logic        func;
        logic [7:0]  cmd_code;
        logic [31:0] argument;
        logic [7:0]  crc_byte;
        logic [7:0]  card_byte;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic        send_valid;
        logic [7:0]  send_byte;
        logic        chip_select;
        logic        done_res;
        logic        timed_out;
        logic        prefix_rejected;
        logic [31:0] response;
    } t_out_item;

    // engine state
    typedef struct packed {
        t_phase      phase;
        logic [2:0]  byte_index;
        logic [7:0]  poll_count;
        logic        prefix_active;
        logic [7:0]  saved_command;
        logic [31:0] saved_argument;
        logic [7:0]  saved_crc;
        logic [31:0] response_accumulator;
        logic        timeout_flag;
        logic        select_level;
    } t_state;

    // command byte currently on the wire
    function automatic logic [7:0] cur_cmd(input logic prefix, input logic [7:0] cmd);
        cur_cmd = prefix ? CMD_APP : (cmd & CMD_MASK);
    endfunction

    // byte idx of the six-byte command frame
    function automatic logic [7:0] frame_byte(
        input logic [2:0]  idx,
        input logic        prefix,
        input logic [7:0]  cmd,
        input logic [31:0] arg,
        input logic [7:0]  crc
    );
        logic [31:0] a;
        a = prefix ? 32'd0 : arg;
        case (idx)
            3'd0:    frame_byte = cur_cmd(prefix, cmd);
            3'd1:    frame_byte = a[31:24];
            3'd2:    frame_byte = a[23:16];
            3'd3:    frame_byte = a[15:8];
            3'd4:    frame_byte = a[7:0];
            default: frame_byte = prefix ? FILL_BYTE : crc;
        endcase
    endfunction

endpackage

`default_nettype wire

FILE: src/sdsc_in_if.sv
// sdsc_in_if: valid/ready channel carrying one input beat
// depends on sdsc_pkg for the payload type
`default_nettype none

interface sdsc_in_if;
    logic               valid;
    logic               ready;
    sdsc_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/sdsc_out_if.sv
// sdsc_out_if: valid/ready channel carrying one result beat
// depends on sdsc_pkg for the payload type
`default_nettype none

interface sdsc_out_if;
    logic                valid;
    logic                ready;
    sdsc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/sdsc_step.sv
// sdsc_step: next-state and result logic for one beat of the command engine
// depends on sdsc_pkg; purely combinational, registered by the top level
`default_nettype none

module sdsc_step (
    input  wire sdsc_pkg::t_state    i_state,
    input  wire sdsc_pkg::t_in_item  i_item,
    input  wire logic [7:0]          i_poll_limit,
    output sdsc_pkg::t_state         o_state,
    output sdsc_pkg::t_out_item      o_result
);
    import sdsc_pkg::*;

    t_state     n;
    t_out_item  res;
    logic       do_start;
    logic       do_finish;
    logic       fill_out;
    logic [7:0] lim;
    logic [7:0] cmd_now;
    logic [7:0] cb;

    assign cb      = i_item.card_byte;
    assign lim     = (i_poll_limit == 8'd0) ? 8'd1 : i_poll_limit;
    assign cmd_now = cur_cmd(i_state.prefix_active, i_state.saved_command);

    always_comb begin
        n         = i_state;
        res       = '0;
        do_start  = 1'b0;
        do_finish = 1'b0;
        fill_out  = 1'b0;

        // phase transitions
        if (i_item.func == FUNC_START) begin
            n.saved_command  = i_item.cmd_code;
            n.saved_argument = i_item.argument;
            n.saved_crc      = i_item.crc_byte;
            n.prefix_active  = i_item.cmd_code[7];
            do_start         = 1'b1;
        end else begin
            unique case (i_state.phase)
                PH_FRAME: begin
                    if (i_state.byte_index < LAST_FRAME_IDX) begin
                        n.byte_index   = i_state.byte_index + 3'd1;
                        res.send_valid = 1'b1;
                        res.send_byte  = frame_byte(n.byte_index, n.prefix_active,
                            n.saved_command, n.saved_argument, n.saved_crc);
                    end else if (cmd_now == CMD_STATUS) begin
                        n.phase  = PH_SDUMMY;
                        fill_out = 1'b1;
                    end else begin
                        n.phase      = PH_POLL;
                        n.poll_count = 8'd1;
                        fill_out     = 1'b1;
                    end
                end
                PH_POLL: begin
                    fill_out = 1'b1;
                    if (cb != FILL_BYTE) begin
                        if (cmd_now == CMD_IF_COND || cmd_now == CMD_READ_OCR) begin
                            n.phase                = PH_WORD;
                            n.byte_index           = 3'd0;
                            n.response_accumulator = 32'd0;
                        end else begin
                            n.response_accumulator = {24'd0, cb};
                            n.phase                = PH_TRAIL;
                        end
                    end else if (i_state.poll_count >= lim) begin
                        n.timeout_flag         = 1'b1;
                        n.response_accumulator = 32'd0;
                        n.phase                = PH_TRAIL;
                    end else begin
                        n.poll_count = i_state.poll_count + 8'd1;
                    end
                end
                PH_SDUMMY: begin
                    n.phase  = PH_SREAD1;
                    fill_out = 1'b1;
                end
                PH_SREAD1: begin
                    n.phase  = PH_SREAD2;
                    fill_out = 1'b1;
                end
                PH_SREAD2: begin
                    fill_out = 1'b1;
                    n.phase  = PH_TRAIL;
                    if (cb == FILL_BYTE) begin
                        n.timeout_flag         = 1'b1;
                        n.response_accumulator = 32'd0;
                    end else begin
                        n.response_accumulator = {24'd0, cb};
                    end
                end
                PH_WORD: begin
                    fill_out               = 1'b1;
                    n.response_accumulator = {i_state.response_accumulator[23:0], cb};
                    if (i_state.byte_index >= LAST_WORD_IDX) begin
                        n.phase = PH_TRAIL;
                    end else begin
                        n.byte_index = i_state.byte_index + 3'd1;
                    end
                end
                PH_TRAIL: begin
                    if (i_state.timeout_flag) begin
                        n.select_level = 1'b1;
                        n.phase        = PH_DESEL;
                        fill_out       = 1'b1;
                    end else begin
                        do_finish = 1'b1;
                    end
                end
                PH_DESEL: begin
                    do_finish = 1'b1;
                end
                default: begin
                    n.phase = PH_IDLE;
                end
            endcase
        end

        // end of a sub-exchange: chain into the main command or complete
        if (do_finish) begin
            if (i_state.prefix_active) begin
                n.prefix_active = 1'b0;
                if (!i_state.timeout_flag && i_state.response_accumulator > 32'd1) begin
                    n.phase             = PH_IDLE;
                    res.done_res        = 1'b1;
                    res.prefix_rejected = 1'b1;
                    res.response        = i_state.response_accumulator;
                end else begin
                    do_start = 1'b1;
                end
            end else begin
                n.phase      = PH_IDLE;
                res.done_res = 1'b1;
                if (i_state.timeout_flag) begin
                    res.timed_out = 1'b1;
                end else begin
                    res.response = i_state.response_accumulator;
                end
            end
        end

        // first frame byte of a command
        if (do_start) begin
            n.phase                = PH_FRAME;
            n.byte_index           = 3'd0;
            n.poll_count           = 8'd0;
            n.timeout_flag         = 1'b0;
            n.response_accumulator = 32'd0;
            n.select_level         = 1'b0;
            res.send_valid         = 1'b1;
            res.send_byte          = frame_byte(3'd0, n.prefix_active, n.saved_command,
                n.saved_argument, n.saved_crc);
        end

        // dummy clock byte
        if (fill_out) begin
            res.send_valid = 1'b1;
            res.send_byte  = FILL_BYTE;
        end

        res.chip_select = n.select_level;
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

`default_nettype wire

FILE: src/sd_spi_command_exchange_core.sv
// sd_spi_command_exchange_core: spi-mode sd command engine, one spi byte per beat
// depends on sdsc_pkg, sdsc_in_if, sdsc_out_if and sdsc_step
//
// usage:
//   i_cmd carries input beats: func 0 starts a command (cmd_code, argument,
//   crc_byte), func 1 hands over the byte the card returned on the last transfer.
//   o_res carries one result beat per input beat: the next byte to clock out
//   with the chip-select level, or completion with flags and response.
//   i_cfg_wr_en / i_cfg_wr_data write the r1 poll limit (write only when idle).
// result timing and throughput:
//   the result of a beat is registered onto o_res in the cycle after it is taken.
//   one beat per cycle is sustained unless o_res stalls; the step logic sits
//   between the input handshake and the result register; state updates in the same cycle.
// reset (synchronous, active low):
//   engine idle, chip select deselected, poll limit 8, no result pending.
// receiver stall:
//   the result register holds its beat; i_cmd.ready stays high while the
//   register is empty or being drained, so a new beat is taken in the same
//   cycle the previous result is taken.
`default_nettype none

module sd_spi_command_exchange_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sdsc_in_if.sink    i_cmd,
    sdsc_out_if.source o_res,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data
);
    import sdsc_pkg::*;

    t_state    r_state;
    t_state    n_state;
    t_out_item r_result;
    t_out_item n_result;
    logic      r_res_valid;
    logic [7:0] r_poll_limit;
    logic      take;

    // input accepted whenever the result register can move on
    assign i_cmd.ready = !r_res_valid || o_res.ready;
    assign take        = i_cmd.valid && i_cmd.ready;

    // step logic
    sdsc_step u_step (
        .i_state      (r_state),
        .i_item       (i_cmd.data),
        .i_poll_limit (r_poll_limit),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit <= POLL_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_poll_limit <= i_cfg_wr_data;
        end
    end

    // engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: PH_IDLE, byte_index: 3'd0, poll_count: 8'd0,
                         prefix_active: 1'b0, saved_command: 8'd0,
                         saved_argument: 32'd0, saved_crc: 8'd0,
                         response_accumulator: 32'd0, timeout_flag: 1'b0,
                         select_level: 1'b1};
        end else if (take) begin
            r_state <= n_state;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (take) begin
            r_res_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_res_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_result <= n_result;
        end
    end

    assign o_res.valid = r_res_valid;
    assign o_res.data  = r_result;

endmodule

`default_nettype wire

FILE: src/sdsc_checker.sv
// sdsc_checker: port-level assertions for the sd spi command engine
// depends on sdsc_pkg; bound to sd_spi_command_exchange_core below
`default_nettype none

module sdsc_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_res_valid,
    input wire logic                i_res_ready,
    input wire sdsc_pkg::t_out_item i_res_data
);
    import sdsc_pkg::*;

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("result beat changed while stalled");

    // no result pending right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_res_valid)
        else $error("result valid after reset");

    // flags and response only come with completion
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.done_res |->
            !i_res_data.timed_out && !i_res_data.prefix_rejected &&
            i_res_data.response == 32'd0)
        else $error("status flags without completion");

    // a timed out exchange ends deselected with zero response
    a_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.timed_out |->
            i_res_data.chip_select && i_res_data.response == 32'd0 &&
            !i_res_data.send_valid)
        else $error("timeout result malformed");

    // no byte to send means a zero byte
    a_idle_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.send_valid |-> i_res_data.send_byte == 8'd0)
        else $error("send byte set without send valid");

endmodule

bind sd_spi_command_exchange_core sdsc_checker u_sdsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_res_data  (o_res.data)
);

`default_nettype wire

FILE: tb/sd_spi_command_exchange_core_tb.sv
// testbench for sd_spi_command_exchange_core: drives command and card-byte beats,
// predicts every result beat with its own engine model and checks them in order
// depends on sdsc_pkg, sdsc_in_if, sdsc_out_if and the core itself
`timescale 1ns / 1ps

module sd_spi_command_exchange_core_tb;
    import sdsc_pkg::*;

    localparam int CLK_HALF = 10;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [7:0] i_cfg_wr_data;

    sdsc_in_if  cmd_ch ();
    sdsc_out_if res_ch ();

    sd_spi_command_exchange_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd_ch),
        .o_res         (res_ch),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // engine model state
    t_phase      eng_phase;
    logic [2:0]  eng_idx;
    logic [7:0]  eng_polls;
    logic        eng_prefix;
    logic [7:0]  eng_cmd;
    logic [31:0] eng_arg;
    logic [7:0]  eng_crc;
    logic [31:0] eng_acc;
    logic        eng_timeout;
    logic        eng_cs;
    logic [7:0]  poll_limit;

    // expected result beats, oldest first
    t_out_item expected_beats[$];

    // traffic shaping
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;

    // bookkeeping
    int err_count;
    int starts_sent;
    int bytes_sent;
    int beats_checked;
    int done_seen;
    int timeouts_seen;
    int rejects_seen;

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // command byte now on the wire
    function automatic logic [7:0] wire_cmd();
        return eng_prefix ? CMD_APP : (eng_cmd & CMD_MASK);
    endfunction

    // byte idx of the six-byte frame, command first and crc last
    function automatic logic [7:0] frame_out(input logic [2:0] idx);
        logic [47:0] frame;
        frame = {wire_cmd(), eng_prefix ? 32'd0 : eng_arg,
                 eng_prefix ? FILL_BYTE : eng_crc};
        return frame[8 * (5 - idx) +: 8];
    endfunction

    // result beat carrying a byte to clock out
    function automatic t_out_item tx_beat(input logic [7:0] tx_val);
        t_out_item r;
        r = '0;
        r.send_valid  = 1'b1;
        r.send_byte   = tx_val;
        r.chip_select = eng_cs;
        return r;
    endfunction

    // result beat closing an exchange
    function automatic t_out_item done_beat(input logic to, input logic rej,
                                            input logic [31:0] resp);
        t_out_item r;
        r = '0;
        r.chip_select     = eng_cs;
        r.done_res        = 1'b1;
        r.timed_out       = to;
        r.prefix_rejected = rej;
        r.response        = resp;
        return r;
    endfunction

    // result beat for a card byte while idle: only the held chip select
    function automatic t_out_item idle_beat();
        t_out_item r;
        r = '0;
        r.chip_select = eng_cs;
        return r;
    endfunction

    function automatic t_out_item begin_frame();
        eng_phase   = PH_FRAME;
        eng_idx     = '0;
        eng_polls   = '0;
        eng_timeout = 1'b0;
        eng_acc     = '0;
        eng_cs      = 1'b0;
        return tx_beat(frame_out(3'd0));
    endfunction

    // end of a cmd55 or of the main command
    function automatic t_out_item close_exchange();
        logic [31:0] r1;
        if (eng_prefix) begin
            eng_prefix = 1'b0;
            if (!eng_timeout && eng_acc > 32'd1) begin
                r1 = eng_acc;
                eng_phase = PH_IDLE;
                return done_beat(1'b0, 1'b1, r1);
            end
            return begin_frame();
        end
        eng_phase = PH_IDLE;
        if (eng_timeout)
            return done_beat(1'b1, 1'b0, 32'd0);
        return done_beat(1'b0, 1'b0, eng_acc);
    endfunction

    // advance the engine model by one input beat
    function automatic t_out_item step_engine(input t_in_item it);
        logic [7:0] lim;
        logic [7:0] cb;
        cb = it.card_byte;
        if (it.func == FUNC_START) begin
            eng_cmd    = it.cmd_code;
            eng_arg    = it.argument;
            eng_crc    = it.crc_byte;
            eng_prefix = it.cmd_code[7];
            return begin_frame();
        end
        case (eng_phase)
            PH_FRAME: begin
                if (eng_idx < LAST_FRAME_IDX) begin
                    eng_idx = eng_idx + 3'd1;
                    return tx_beat(frame_out(eng_idx));
                end
                if (wire_cmd() == CMD_STATUS) begin
                    eng_phase = PH_SDUMMY;
                end else begin
                    eng_phase = PH_POLL;
                    eng_polls = 8'd1;
                end
                return tx_beat(FILL_BYTE);
            end
            PH_POLL: begin
                lim = (poll_limit != 8'd0) ? poll_limit : 8'd1;
                if (cb != FILL_BYTE) begin
                    eng_acc = {24'd0, cb};
                    if (wire_cmd() == CMD_IF_COND || wire_cmd() == CMD_READ_OCR) begin
                        eng_phase = PH_WORD;
                        eng_idx   = '0;
                        eng_acc   = '0;
                    end else begin
                        eng_phase = PH_TRAIL;
                    end
                end else if (eng_polls >= lim) begin
                    eng_timeout = 1'b1;
                    eng_acc     = '0;
                    eng_phase   = PH_TRAIL;
                end else begin
                    eng_polls = eng_polls + 8'd1;
                end
                return tx_beat(FILL_BYTE);
            end
            PH_SDUMMY: begin
                eng_phase = PH_SREAD1;
                return tx_beat(FILL_BYTE);
            end
            PH_SREAD1: begin
                eng_phase = PH_SREAD2;
                return tx_beat(FILL_BYTE);
            end
            PH_SREAD2: begin
                // all-ones on the second status read means no card
                if (cb == FILL_BYTE) begin
                    eng_timeout = 1'b1;
                    eng_acc     = '0;
                end else begin
                    eng_acc = {24'd0, cb};
                end
                eng_phase = PH_TRAIL;
                return tx_beat(FILL_BYTE);
            end
            PH_WORD: begin
                eng_acc = {eng_acc[23:0], cb};
                if (eng_idx >= LAST_WORD_IDX)
                    eng_phase = PH_TRAIL;
                else
                    eng_idx = eng_idx + 3'd1;
                return tx_beat(FILL_BYTE);
            end
            PH_TRAIL: begin
                if (eng_timeout) begin
                    eng_cs    = 1'b1;
                    eng_phase = PH_DESEL;
                    return tx_beat(FILL_BYTE);
                end
                return close_exchange();
            end
            PH_DESEL: begin
                return close_exchange();
            end
            default: begin
                // card byte while idle is ignored
                eng_phase = PH_IDLE;
                return idle_beat();
            end
        endcase
    endfunction

    // send one beat: random idle gaps, then hold until taken
    task automatic send_beat(input t_in_item it);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= it;
        @(posedge i_clk);
        while (cmd_ch.ready !== 1'b1) @(posedge i_clk);
        expected_beats.push_back(step_engine(it));
    endtask

    task automatic send_start(input logic [7:0] cmd, input logic [31:0] arg,
                              input logic [7:0] crc);
        t_in_item it;
        it.func      = FUNC_START;
        it.cmd_code  = cmd;
        it.argument  = arg;
        it.crc_byte  = crc;
        it.card_byte = 8'($urandom_range(0, 255));
        starts_sent++;
        send_beat(it);
    endtask

    task automatic send_card(input logic [7:0] card_val);
        t_in_item it;
        it.func      = FUNC_BYTE;
        it.cmd_code  = 8'($urandom_range(0, 255));
        it.argument  = $urandom;
        it.crc_byte  = 8'($urandom_range(0, 255));
        it.card_byte = card_val;
        bytes_sent++;
        send_beat(it);
    endtask

    // keep answering with one byte until the exchange closes
    task automatic drain_with(input logic [7:0] card_val);
        while (eng_phase != PH_IDLE) send_card(card_val);
    endtask

    // drop valid and wait for every expected beat
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_ch.valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
    endtask

    // poll limit write, only with nothing in flight
    task automatic set_poll_limit(input logic [7:0] lim);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= lim;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        poll_limit = lim;
    endtask

    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CMD_STATUS;
            1:       c = CMD_IF_COND;
            2:       c = CMD_READ_OCR;
            3:       c = CMD_APP;
            4:       c = 8'h40 | 8'($urandom_range(0, 63));
            default: c = 8'($urandom_range(0, 255));
        endcase
        if ($urandom_range(0, 99) < 35)
            c[7] = 1'b1;
        return c;
    endfunction

    // card reply shaped by what the engine waits for
    function automatic logic [7:0] pick_card_byte();
        int r;
        r = $urandom_range(0, 99);
        case (eng_phase)
            PH_POLL: begin
                if (r < 65) return FILL_BYTE;
                if (r < 82) return 8'($urandom_range(0, 1));
                return 8'($urandom_range(0, 255));
            end
            PH_SREAD2: return (r < 25) ? FILL_BYTE : 8'($urandom_range(0, 255));
            default:   return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // mostly complete exchanges, some restarts and idle noise
    task automatic run_traffic(input int n_items, input int idle_pct, input int stall_pct);
        int sent;
        int r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (eng_phase == PH_IDLE && r < 5) begin
                send_card(8'($urandom_range(0, 255)));
            end else if (eng_phase == PH_IDLE || r < 3) begin
                send_start(pick_command(), $urandom, 8'($urandom_range(0, 255)));
                sent++;
            end else begin
                send_card(pick_card_byte());
                sent++;
            end
        end
        drain_with(8'h00);
        wait_drained();
    endtask

    // receiver: random stalls, or a long counted hold-off
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each taken result with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        t_out_item got;
        if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            got = res_ch.data;
            if (expected_beats.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected result beat %h at %0t", got, $realtime);
            end else begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (want.done_res) done_seen++;
                if (want.timed_out) timeouts_seen++;
                if (want.prefix_rejected) rejects_seen++;
                if (got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
                    got.chip_select !== want.chip_select || got.done_res !== want.done_res ||
                    got.timed_out !== want.timed_out ||
                    got.prefix_rejected !== want.prefix_rejected ||
                    got.response !== want.response) begin
                    err_count++;
                    if (err_count <= 10)
                        $display({"mismatch at %0t: exp v=%b b=%h cs=%b d=%b to=%b rej=%b r=%h",
                                  " got v=%b b=%h cs=%b d=%b to=%b rej=%b r=%h"},
                                 $realtime, want.send_valid, want.send_byte,
                                 want.chip_select, want.done_res, want.timed_out,
                                 want.prefix_rejected, want.response, got.send_valid,
                                 got.send_byte, got.chip_select, got.done_res,
                                 got.timed_out, got.prefix_rejected, got.response);
                end
            end
        end
    end

    // card bytes with no exchange running
    task automatic test_idle_bytes();
        send_card(8'h00);
        send_card(FILL_BYTE);
        wait_drained();
    endtask

    // field extremes, r1 timeout on the shortest poll
    task automatic test_frame_extremes();
        set_poll_limit(8'd1);
        send_start(8'h00, 32'hFFFF_FFFF, 8'h00);
        drain_with(FILL_BYTE);
        send_start(8'h7F, 32'h0000_0000, 8'hFF);
        drain_with(8'h00);
    endtask

    // cmd55 gets no answer, main command still runs
    task automatic test_prefix_timeout();
        send_start(8'h80 | CMD_IF_COND, 32'h0000_01AA, 8'h87);
        while (eng_phase != PH_IDLE)
            send_card(eng_prefix ? FILL_BYTE : 8'hA5);
        send_start(8'hFF, 32'h0, 8'h00);
        drain_with(FILL_BYTE);
    endtask

    // cmd55 answered above 1 ends the exchange, r1 of 1 lets it through
    task automatic test_prefix_reply();
        set_poll_limit(8'd255);
        send_start(8'hC0, 32'h1234_5678, 8'h95);
        drain_with(8'h02);
        send_start(8'hC0 | 8'h29, 32'h4000_0000, 8'h77);
        drain_with(8'h01);
    endtask

    // status read: dummy then two reads, all-ones on the second means timeout
    task automatic test_status_read();
        send_start(CMD_STATUS, 32'h0, 8'hFF);
        drain_with(FILL_BYTE);
        send_start(CMD_STATUS, 32'h0, 8'h0D);
        drain_with(8'h5A);
    endtask

    // ocr word after a few fill bytes
    task automatic test_word_read();
        int k;
        send_start(CMD_READ_OCR, 32'h0, 8'hFD);
        send_card(8'h00);
        for (k = 0; eng_phase != PH_IDLE; k++)
            send_card((eng_phase == PH_POLL && k < 9) ? FILL_BYTE : 8'(8'hC0 + k));
    endtask

    // new command abandons the running one
    task automatic test_restart_busy();
        send_start(CMD_IF_COND, 32'h0000_01AA, 8'h87);
        send_card(8'h00);
        send_card(8'h00);
        send_start(CMD_STATUS, 32'hA5A5_5A5A, 8'h01);
        drain_with(8'h3C);
        wait_drained();
    endtask

    // long receiver hold-off while beats keep coming, then a sender pause
    task automatic test_backpressure();
        int k;
        set_poll_limit(8'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        send_start(CMD_READ_OCR, $urandom, 8'($urandom_range(0, 255)));
        for (k = 0; k < 6; k++) send_card(pick_card_byte());
        wait_drained();
        for (k = 0; k < 6; k++) send_card(pick_card_byte());
        drain_with(8'h00);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        set_poll_limit(8'd8);
        run_traffic(300, 0, 0);
        set_poll_limit(8'd1);
        run_traffic(300, 78, 0);
        set_poll_limit(8'd255);
        run_traffic(300, 0, 78);
        set_poll_limit(8'($urandom_range(2, 254)));
        run_traffic(300, 32, 32);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        res_ch.ready   = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        err_count      = 0;
        starts_sent    = 0;
        bytes_sent     = 0;
        beats_checked  = 0;
        done_seen      = 0;
        timeouts_seen  = 0;
        rejects_seen   = 0;
        // engine model after reset
        eng_phase   = PH_IDLE;
        eng_idx     = '0;
        eng_polls   = '0;
        eng_prefix  = 1'b0;
        eng_cmd     = '0;
        eng_arg     = '0;
        eng_crc     = '0;
        eng_acc     = '0;
        eng_timeout = 1'b0;
        eng_cs      = 1'b1;
        poll_limit  = POLL_LIMIT_RESET;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_bytes();
        test_frame_extremes();
        test_prefix_timeout();
        test_prefix_reply();
        test_status_read();
        test_word_read();
        test_restart_busy();
        test_backpressure();
        test_random_traffic();

        recv_stall_pct = 0;
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("sent %0d command starts and %0d card bytes, checked %0d result beats",
                 starts_sent, bytes_sent, beats_checked);
        $display("saw %0d completions, %0d timeouts, %0d cmd55 rejections, %0d mismatches",
                 done_seen, timeouts_seen, rejects_seen, err_count);
        if (err_count == 0 && expected_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
